// ----- rtl/indexed_list_engine_unit_macros.svh -----
// Assertion macros used by the indexed list engine datapath.
`ifndef INDEXED_LIST_ENGINE_UNIT_MACROS_SVH
`define INDEXED_LIST_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ILE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ile_pkg.sv -----
// Package with constants, types and command/status structs of the list engine.
`timescale 1ns / 1ps
`default_nettype none

package ile_pkg;

  localparam int CAPACITY  = 64;
  localparam int LINK_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int OPCODE_W  = 2;
  localparam int POS_W     = 7;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int CMP_W     = (POS_W > LINK_W) ? POS_W : LINK_W;

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CMP_W-1:0]  cmp_t;

  localparam link_t NULL_LINK = link_t'(CAPACITY);
  localparam link_t FULL_LEN  = link_t'(CAPACITY);

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } ile_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } ile_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_TAKE,
    S_WALK0,
    S_WALKN,
    S_ILINK,
    S_IFIX,
    S_DNODE,
    S_DNEXT,
    S_DHEAD,
    S_DFREE,
    S_RVAL,
    S_FINISH
  } ile_state_t;

  // Link memory read address source.
  typedef enum logic [1:0] {
    RA_CUR  = 2'd0,
    RA_LINK = 2'd1,
    RA_FREE = 2'd2,
    RA_HEAD = 2'd3
  } ile_raddr_t;

  // Link memory write: which entry and which data.
  typedef enum logic [2:0] {
    LW_NONE,
    LW_NODE_HEAD,
    LW_NODE_FREE,
    LW_NODE_LINK,
    LW_CUR_NODE,
    LW_CUR_LINK
  } ile_lwr_t;

  // Working node register load source.
  typedef enum logic [1:0] {
    NL_NONE = 2'd0,
    NL_FREE = 2'd1,
    NL_HEAD = 2'd2,
    NL_LINK = 2'd3
  } ile_nload_t;

  typedef struct packed {
    logic        in_ready;
    ile_raddr_t  ra_sel;
    ile_lwr_t    lwr;
    ile_nload_t  node_ld;
    logic        value_we;
    logic        free_from_link;
    logic        free_from_node;
    logic        head_from_node;
    logic        head_from_link;
    logic        len_inc;
    logic        len_dec;
    logic        walk_init;
    logic        walk_minus1;
    logic        walk_step;
    logic        set_status;
    ile_status_t status_code;
    logic        rdval_load;
    logic        publish;
  } ile_cmd_t;

  typedef struct packed {
    logic    in_fire;
    ile_op_t opcode;
    logic    pos_zero;
    logic    pos_gt_len;
    logic    pos_ge_len;
    logic    len_zero;
    logic    free_null;
    logic    cnt_zero;
    logic    out_free;
  } ile_stat_t;

endpackage

`default_nettype wire

// ----- rtl/ile_req_if.sv -----
// Request channel interface: opcode, position and value with valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface ile_req_if;
  logic                               valid;
  logic                               ready;
  logic [ile_pkg::OPCODE_W-1:0]       opcode;
  logic [ile_pkg::POS_W-1:0]          position;
  logic signed [ile_pkg::VALUE_W-1:0] item_value;

  modport source (output valid, opcode, position, item_value, input ready);
  modport sink (input valid, opcode, position, item_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/ile_rsp_if.sv -----
// Result channel interface: status and read value with valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface ile_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [ile_pkg::STATUS_W-1:0]       status;
  logic signed [ile_pkg::VALUE_W-1:0] read_value;

  modport source (output valid, status, read_value, input ready);
  modport sink (input valid, status, read_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/ile_ctrl.sv -----
// Sequencer of the list engine: decides each step of a request.
`timescale 1ns / 1ps
`default_nettype none

module ile_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ile_pkg::ile_stat_t stat,
  output      ile_pkg::ile_cmd_t  cmd
);

  ile_pkg::ile_state_t state;
  ile_pkg::ile_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ile_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ile_pkg::S_IDLE: begin
        if (stat.in_fire) state_next = ile_pkg::S_CHECK;
      end
      ile_pkg::S_CHECK: begin
        unique case (stat.opcode)
          ile_pkg::OP_APPEND, ile_pkg::OP_INSERT: begin
            priority if (stat.pos_gt_len || stat.free_null) state_next = ile_pkg::S_FINISH;
            else state_next = ile_pkg::S_TAKE;
          end
          ile_pkg::OP_DELETE: begin
            priority if (stat.len_zero || stat.pos_ge_len) state_next = ile_pkg::S_FINISH;
            else if (stat.pos_zero) state_next = ile_pkg::S_DHEAD;
            else state_next = ile_pkg::S_WALK0;
          end
          ile_pkg::OP_READ: begin
            priority if (stat.pos_ge_len) state_next = ile_pkg::S_FINISH;
            else state_next = ile_pkg::S_WALK0;
          end
        endcase
      end
      ile_pkg::S_TAKE: begin
        if (stat.pos_zero) state_next = ile_pkg::S_FINISH;
        else state_next = ile_pkg::S_WALK0;
      end
      ile_pkg::S_WALK0, ile_pkg::S_WALKN: begin
        if (stat.cnt_zero) begin
          unique case (stat.opcode)
            ile_pkg::OP_READ:   state_next = ile_pkg::S_RVAL;
            ile_pkg::OP_DELETE: state_next = ile_pkg::S_DNODE;
            ile_pkg::OP_APPEND, ile_pkg::OP_INSERT: state_next = ile_pkg::S_ILINK;
          endcase
        end else begin
          state_next = ile_pkg::S_WALKN;
        end
      end
      ile_pkg::S_ILINK:  state_next = ile_pkg::S_IFIX;
      ile_pkg::S_IFIX:   state_next = ile_pkg::S_FINISH;
      ile_pkg::S_DNODE:  state_next = ile_pkg::S_DNEXT;
      ile_pkg::S_DNEXT:  state_next = ile_pkg::S_DFREE;
      ile_pkg::S_DHEAD:  state_next = ile_pkg::S_DFREE;
      ile_pkg::S_DFREE:  state_next = ile_pkg::S_FINISH;
      ile_pkg::S_RVAL:   state_next = ile_pkg::S_FINISH;
      ile_pkg::S_FINISH: begin
        if (stat.out_free) state_next = ile_pkg::S_IDLE;
      end
      default: state_next = ile_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    unique case (state)
      ile_pkg::S_IDLE: cmd.in_ready = 1'b1;
      ile_pkg::S_CHECK: begin
        unique case (stat.opcode)
          ile_pkg::OP_APPEND, ile_pkg::OP_INSERT: begin
            priority if (stat.pos_gt_len) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ile_pkg::ST_RANGE;
            end else if (stat.free_null) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ile_pkg::ST_FULL;
            end else begin
              cmd.node_ld  = ile_pkg::NL_FREE;
              cmd.value_we = 1'b1;
              cmd.ra_sel   = ile_pkg::RA_FREE;
            end
          end
          ile_pkg::OP_DELETE: begin
            priority if (stat.len_zero) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ile_pkg::ST_EMPTY;
            end else if (stat.pos_ge_len) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ile_pkg::ST_RANGE;
            end else if (stat.pos_zero) begin
              cmd.node_ld = ile_pkg::NL_HEAD;
              cmd.ra_sel  = ile_pkg::RA_HEAD;
            end else begin
              cmd.walk_init   = 1'b1;
              cmd.walk_minus1 = 1'b1;
            end
          end
          ile_pkg::OP_READ: begin
            priority if (stat.pos_ge_len) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ile_pkg::ST_RANGE;
            end else begin
              cmd.walk_init = 1'b1;
            end
          end
        endcase
      end
      ile_pkg::S_TAKE: begin
        cmd.free_from_link = 1'b1;
        if (stat.pos_zero) begin
          cmd.lwr            = ile_pkg::LW_NODE_HEAD;
          cmd.head_from_node = 1'b1;
          cmd.len_inc        = 1'b1;
          cmd.set_status     = 1'b1;
          cmd.status_code    = ile_pkg::ST_OK;
        end else begin
          cmd.walk_init   = 1'b1;
          cmd.walk_minus1 = 1'b1;
        end
      end
      ile_pkg::S_WALK0: begin
        cmd.ra_sel    = ile_pkg::RA_CUR;
        cmd.walk_step = 1'b1;
      end
      ile_pkg::S_WALKN: begin
        cmd.ra_sel    = ile_pkg::RA_LINK;
        cmd.walk_step = 1'b1;
      end
      ile_pkg::S_ILINK: cmd.lwr = ile_pkg::LW_NODE_LINK;
      ile_pkg::S_IFIX: begin
        cmd.lwr         = ile_pkg::LW_CUR_NODE;
        cmd.len_inc     = 1'b1;
        cmd.set_status  = 1'b1;
        cmd.status_code = ile_pkg::ST_OK;
      end
      ile_pkg::S_DNODE: begin
        cmd.node_ld = ile_pkg::NL_LINK;
        cmd.ra_sel  = ile_pkg::RA_LINK;
      end
      ile_pkg::S_DNEXT: cmd.lwr = ile_pkg::LW_CUR_LINK;
      ile_pkg::S_DHEAD: cmd.head_from_link = 1'b1;
      ile_pkg::S_DFREE: begin
        cmd.lwr            = ile_pkg::LW_NODE_FREE;
        cmd.free_from_node = 1'b1;
        cmd.len_dec        = 1'b1;
        cmd.set_status     = 1'b1;
        cmd.status_code    = ile_pkg::ST_OK;
      end
      ile_pkg::S_RVAL: begin
        cmd.rdval_load  = 1'b1;
        cmd.set_status  = 1'b1;
        cmd.status_code = ile_pkg::ST_OK;
      end
      ile_pkg::S_FINISH: cmd.publish = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/ile_dpath.sv -----
// Datapath of the list engine: node stores, pointers, walk counter, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_list_engine_unit_macros.svh"

module ile_dpath (
  input  wire logic              clk,
  input  wire logic              rst,
  ile_req_if.sink                req,
  ile_rsp_if.source              rsp,
  input  wire ile_pkg::ile_cmd_t  cmd,
  output      ile_pkg::ile_stat_t stat
);

  // Node stores
  ile_pkg::link_t                 link_mem [ile_pkg::CAPACITY];
  logic [ile_pkg::CAPACITY-1:0]   link_valid;
  logic [ile_pkg::VALUE_W-1:0]    value_mem [ile_pkg::CAPACITY];

  ile_pkg::link_t              link_mem_q;
  logic                        link_vld_q;
  ile_pkg::idx_t               link_addr_q;
  logic [ile_pkg::VALUE_W-1:0] value_q;
  ile_pkg::link_t              link_rdata;

  // Pointers and request registers
  ile_pkg::link_t              head;
  ile_pkg::link_t              free;
  ile_pkg::link_t              len;
  ile_pkg::link_t              node;
  ile_pkg::link_t              cur;
  ile_pkg::cmp_t               cnt;
  ile_pkg::ile_op_t            op_q;
  ile_pkg::cmp_t               pos_q;
  logic [ile_pkg::VALUE_W-1:0] val_q;
  ile_pkg::ile_status_t        status_q;
  logic [ile_pkg::VALUE_W-1:0] rdval_q;

  // Result register
  logic                        out_valid;
  ile_pkg::ile_status_t        rsp_status_q;
  logic [ile_pkg::VALUE_W-1:0] rsp_value_q;

  ile_pkg::link_t ra_addr;
  ile_pkg::idx_t  rd_idx;
  logic           lw_en;
  ile_pkg::link_t lw_addr;
  ile_pkg::link_t lw_data;
  logic           in_fire;

  assign in_fire = req.valid && req.ready;
  assign req.ready = cmd.in_ready;

  // A link never written reads as its reset value: the next node index.
  assign link_rdata = link_vld_q ? link_mem_q
                                 : ile_pkg::link_t'(link_addr_q) + ile_pkg::link_t'(1);

  always_comb begin
    unique case (cmd.ra_sel)
      ile_pkg::RA_CUR:  ra_addr = cur;
      ile_pkg::RA_LINK: ra_addr = link_rdata;
      ile_pkg::RA_FREE: ra_addr = free;
      ile_pkg::RA_HEAD: ra_addr = head;
    endcase
  end

  assign rd_idx = ra_addr[ile_pkg::IDX_W-1:0];

  always_comb begin
    lw_en   = 1'b1;
    lw_addr = node;
    lw_data = head;
    unique case (cmd.lwr)
      ile_pkg::LW_NONE:      lw_en = 1'b0;
      ile_pkg::LW_NODE_HEAD: lw_data = head;
      ile_pkg::LW_NODE_FREE: lw_data = free;
      ile_pkg::LW_NODE_LINK: lw_data = link_rdata;
      ile_pkg::LW_CUR_NODE: begin
        lw_addr = cur;
        lw_data = node;
      end
      ile_pkg::LW_CUR_LINK: begin
        lw_addr = cur;
        lw_data = link_rdata;
      end
      default: lw_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lw_en) link_mem[lw_addr[ile_pkg::IDX_W-1:0]] <= lw_data;
    link_mem_q  <= link_mem[rd_idx];
    link_vld_q  <= link_valid[rd_idx];
    link_addr_q <= rd_idx;
  end

  always_ff @(posedge clk) begin
    if (cmd.value_we) value_mem[free[ile_pkg::IDX_W-1:0]] <= val_q;
    value_q <= value_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_valid <= '0;
    end else if (lw_en) begin
      link_valid[lw_addr[ile_pkg::IDX_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= ile_pkg::NULL_LINK;
      free      <= '0;
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      priority if (cmd.head_from_node) head <= node;
      else if (cmd.head_from_link) head <= link_rdata;
      priority if (cmd.free_from_link) free <= link_rdata;
      else if (cmd.free_from_node) free <= node;
      priority if (cmd.len_inc) len <= len + ile_pkg::link_t'(1);
      else if (cmd.len_dec) len <= len - ile_pkg::link_t'(1);
      priority if (cmd.publish) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q  <= ile_pkg::ile_op_t'(req.opcode);
      pos_q <= (ile_pkg::ile_op_t'(req.opcode) == ile_pkg::OP_APPEND)
               ? ile_pkg::cmp_t'(len) : ile_pkg::cmp_t'(req.position);
      val_q <= req.item_value;
    end
    unique case (cmd.node_ld)
      ile_pkg::NL_NONE: node <= node;
      ile_pkg::NL_FREE: node <= free;
      ile_pkg::NL_HEAD: node <= head;
      ile_pkg::NL_LINK: node <= link_rdata;
    endcase
    priority if (cmd.walk_init) begin
      cur <= head;
      cnt <= cmd.walk_minus1 ? pos_q - ile_pkg::cmp_t'(1) : pos_q;
    end else if (cmd.walk_step) begin
      cur <= ra_addr;
      if (cnt != '0) cnt <= cnt - ile_pkg::cmp_t'(1);
    end
    if (cmd.set_status) status_q <= cmd.status_code;
    priority if (in_fire) rdval_q <= '0;
    else if (cmd.rdval_load) rdval_q <= value_q;
    if (cmd.publish) begin
      rsp_status_q <= status_q;
      rsp_value_q  <= rdval_q;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = rsp_status_q;
  assign rsp.read_value = rsp_value_q;

  always_comb begin
    stat            = '0;
    stat.in_fire    = in_fire;
    stat.opcode     = op_q;
    stat.pos_zero   = (pos_q == '0);
    stat.pos_gt_len = (pos_q > ile_pkg::cmp_t'(len));
    stat.pos_ge_len = (pos_q >= ile_pkg::cmp_t'(len));
    stat.len_zero   = (len == '0);
    stat.free_null  = (free == ile_pkg::NULL_LINK);
    stat.cnt_zero   = (cnt == '0);
    stat.out_free   = !out_valid || rsp.ready;
  end

  `ILE_ASSERT_NOW(a_full_matches_len, req.ready, ((free == ile_pkg::NULL_LINK) == (len == ile_pkg::FULL_LEN)), "free list and length disagree")
  `ILE_ASSERT_NOW(a_empty_matches_len, req.ready, ((head == ile_pkg::NULL_LINK) == (len == '0)), "head pointer and length disagree")
  `ILE_ASSERT_NOW(a_no_null_write, lw_en, (lw_addr != ile_pkg::NULL_LINK), "link write to null node")
  `ILE_ASSERT_NEXT(a_one_at_a_time, in_fire, !req.ready, "new item taken while one is in work")

endmodule

`default_nettype wire

// ----- rtl/indexed_list_engine_unit.sv -----
// Top level of the indexed list engine: sequencer plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of signed 32-bit values held in a 64-node store chained by
// next links, with unused nodes on a free list. Each request item appends,
// inserts at a position, deletes at a position or reads at a position, and
// gives exactly one result item with a status (ok, out of range, empty,
// full) and the value read (zero unless a read succeeds). One request is in
// work at a time. A position is found by walking links from the head, one
// link-memory read per cycle, so the walk sets the time; a rejected request
// skips the walk, as do an insert and a delete at position 0 (an append
// uses the length as its position). The finished result waits for the
// output register to free up, and the block then goes back to idle. The
// result sits in an output register, so the next request is taken while
// an earlier result still waits to be read. Reset clears a valid bit per
// node in the link store, so unwritten links read as their free-list
// reset value.
module indexed_list_engine_unit (
  input  wire logic clk,
  input  wire logic rst,
  ile_req_if.sink   req,
  ile_rsp_if.source rsp
);

  ile_pkg::ile_cmd_t  cmd;
  ile_pkg::ile_stat_t stat;

  // Sequencer: walks each request through check, walk and write-back.
  ile_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // Datapath: node stores, pointers and the result register.
  ile_dpath u_dpath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the indexed list engine: directed table, then random requests.
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_ITEMS = 501;  // split evenly over the three idling phases
  localparam int STALL_LIMIT  = 2000; // cycles with no item on either channel
  localparam int DRAIN_CYCLES = 80;   // deepest walk plus set-up and write-back

  // One result item as the block should produce it.
  typedef struct {
    ile_pkg::ile_status_t status;
    logic signed [31:0]   value;
  } list_result_t;

  // One row of the directed table. Rows with known_result set carry the
  // result typed in; the rest take it from the list mirror.
  typedef struct {
    ile_pkg::ile_op_t     op;
    logic [6:0]           pos;
    logic signed [31:0]   val;
    bit                   known_result;
    ile_pkg::ile_status_t status;
    logic signed [31:0]   value;
  } plan_row_t;

  logic clk;
  logic rst;

  ile_req_if req_ch ();
  ile_rsp_if rsp_ch ();

  indexed_list_engine_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Mirror of the list contents in order, head first.
  logic signed [31:0] stored_values[$];
  // Results owed by the block, oldest first.
  list_result_t       pending_results[$];

  int err_count    = 0;
  int stall_cycles = 0;
  int snd_idle_pct = 34;
  int rsp_idle_pct = 82;

  // Directed table: empty-list errors first, then growth, range edges,
  // deletes at tail, middle and head, and a drain back to empty.
  plan_row_t directed_plan [25] = '{
    '{ile_pkg::OP_READ,   7'd0,   32'sd0,         1'b1, ile_pkg::ST_RANGE, 32'sd0},
    '{ile_pkg::OP_DELETE, 7'd0,   32'sd0,         1'b1, ile_pkg::ST_EMPTY, 32'sd0},
    '{ile_pkg::OP_DELETE, 7'd127, 32'sd0,         1'b1, ile_pkg::ST_EMPTY, 32'sd0},
    '{ile_pkg::OP_INSERT, 7'd1,   32'sd5,         1'b1, ile_pkg::ST_RANGE, 32'sd0},
    '{ile_pkg::OP_READ,   7'd127, 32'sd0,         1'b1, ile_pkg::ST_RANGE, 32'sd0},
    '{ile_pkg::OP_INSERT, 7'd0,   32'sh7fff_ffff, 1'b1, ile_pkg::ST_OK,    32'sd0},
    '{ile_pkg::OP_APPEND, 7'd127, 32'sh8000_0000, 1'b1, ile_pkg::ST_OK,    32'sd0},
    '{ile_pkg::OP_READ,   7'd0,   32'sd0,         1'b1, ile_pkg::ST_OK,    32'sh7fff_ffff},
    '{ile_pkg::OP_READ,   7'd1,   32'sh1234_5678, 1'b1, ile_pkg::ST_OK,    32'sh8000_0000},
    '{ile_pkg::OP_READ,   7'd2,   32'sd0,         1'b1, ile_pkg::ST_RANGE, 32'sd0},
    '{ile_pkg::OP_INSERT, 7'd3,   32'sd9,         1'b1, ile_pkg::ST_RANGE, 32'sd0},
    '{ile_pkg::OP_INSERT, 7'd2,   32'shffff_ffff, 1'b1, ile_pkg::ST_OK,    32'sd0},
    '{ile_pkg::OP_INSERT, 7'd1,   32'sd0,         1'b0, ile_pkg::ST_OK,    32'sd0},
    '{ile_pkg::OP_INSERT, 7'd0,   32'sh5a5a_5a5a, 1'b0, ile_pkg::ST_OK,    32'sd0},
    '{ile_pkg::OP_READ,   7'd4,   32'sd0,         1'b0, ile_pkg::ST_OK,    32'sd0},
    '{ile_pkg::OP_READ,   7'd64,  32'sd0,         1'b1, ile_pkg::ST_RANGE, 32'sd0},
    '{ile_pkg::OP_DELETE, 7'd5,   32'sd0,         1'b1, ile_pkg::ST_RANGE, 32'sd0},
    '{ile_pkg::OP_DELETE, 7'd4,   32'sd0,         1'b0, ile_pkg::ST_OK,    32'sd0},
    '{ile_pkg::OP_DELETE, 7'd2,   32'sd0,         1'b0, ile_pkg::ST_OK,    32'sd0},
    '{ile_pkg::OP_DELETE, 7'd0,   32'sd0,         1'b0, ile_pkg::ST_OK,    32'sd0},
    '{ile_pkg::OP_APPEND, 7'h55,  32'sd1,         1'b0, ile_pkg::ST_OK,    32'sd0},
    '{ile_pkg::OP_DELETE, 7'd0,   32'sd0,         1'b0, ile_pkg::ST_OK,    32'sd0},
    '{ile_pkg::OP_DELETE, 7'd1,   32'sd0,         1'b0, ile_pkg::ST_OK,    32'sd0},
    '{ile_pkg::OP_DELETE, 7'd0,   32'sd0,         1'b0, ile_pkg::ST_OK,    32'sd0},
    '{ile_pkg::OP_DELETE, 7'd0,   32'sd0,         1'b1, ile_pkg::ST_EMPTY, 32'sd0}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    err_count++;
  endtask

  // Apply one request to the list mirror and return the result it owes.
  // Insert checks the position before the free space; delete checks for
  // an empty list before the position; a read of an empty list is a
  // range error. Append is an insert at the current length.
  function automatic list_result_t apply_request(ile_pkg::ile_op_t op, logic [6:0] pos,
                                                 logic signed [31:0] val);
    list_result_t res;
    int unsigned  at;
    int unsigned  len;
    len        = stored_values.size();
    at         = (op == ile_pkg::OP_APPEND) ? len : pos;
    res.status = ile_pkg::ST_OK;
    res.value  = '0;
    case (op)
      ile_pkg::OP_APPEND, ile_pkg::OP_INSERT: begin
        if (at > len)                      res.status = ile_pkg::ST_RANGE;
        else if (len >= ile_pkg::CAPACITY) res.status = ile_pkg::ST_FULL;
        else                               stored_values.insert(at, val);
      end
      ile_pkg::OP_DELETE: begin
        if (len == 0)        res.status = ile_pkg::ST_EMPTY;
        else if (at >= len)  res.status = ile_pkg::ST_RANGE;
        else                 stored_values.delete(at);
      end
      default: begin
        if (at >= len) res.status = ile_pkg::ST_RANGE;
        else           res.value  = stored_values[at];
      end
    endcase
    return res;
  endfunction

  // Hold the request until the block takes it, then log what it owes.
  // Called at a rising edge; valid is only lowered for an idle gap, so it
  // stays high between back-to-back items.
  task automatic send_request(ile_pkg::ile_op_t op, logic [6:0] pos,
                              logic signed [31:0] val, bit known_result,
                              ile_pkg::ile_status_t t_status,
                              logic signed [31:0] t_value);
    list_result_t predicted;
    while ($urandom_range(99) < snd_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= op;
    req_ch.position   <= pos;
    req_ch.item_value <= val;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_request(op, pos, val);
    if (known_result) begin
      predicted.status = t_status;
      predicted.value  = t_value;
    end
    pending_results.insert(pending_results.size(), predicted);
  endtask

  // Receiver: stall at random per the current idling share.
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
  end

  // Check every result item against the oldest owed result.
  always @(posedge clk) begin
    list_result_t owed;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result item status %0d with no request outstanding",
                                  rsp_ch.status));
      end else begin
        owed = pending_results.pop_front();
        if (rsp_ch.status !== owed.status)
          report_mismatch($sformatf("status %0d, want %0d (%s)", rsp_ch.status,
                                    owed.status, owed.status.name()));
        if (rsp_ch.read_value !== owed.value)
          report_mismatch($sformatf("read_value %0d, want %0d", rsp_ch.read_value,
                                    owed.value));
      end
    end
  end

  // Watchdog: end the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned      len;
    int unsigned      pick;
    bit               growing;
    ile_pkg::ile_op_t op;
    logic [6:0]       pos;

    growing           = 1'b1;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.opcode     <= ile_pkg::OP_APPEND;
    req_ch.position   <= '0;
    req_ch.item_value <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table under the first idling phase.
    foreach (directed_plan[i]) begin
      send_request(directed_plan[i].op, directed_plan[i].pos, directed_plan[i].val,
                   directed_plan[i].known_result, directed_plan[i].status,
                   directed_plan[i].value);
    end

    // Random part: alternate between filling the store up to full and
    // draining it back to empty, so that deep walks and the full case come
    // up often. Most positions fall in range; the rest span all 7 bits.
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 82 : 0;
      rsp_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 34 : 0;
      repeat (RANDOM_ITEMS / 3) begin
        len = stored_values.size();
        if (len == ile_pkg::CAPACITY && $urandom_range(2) == 0) growing = 1'b0;
        else if (len == 0) growing = 1'b1;
        pick = $urandom_range(99);
        if (growing)
          op = (pick < 35) ? ile_pkg::OP_APPEND : (pick < 72) ? ile_pkg::OP_INSERT :
               (pick < 84) ? ile_pkg::OP_DELETE : ile_pkg::OP_READ;
        else
          op = (pick < 5) ? ile_pkg::OP_APPEND : (pick < 12) ? ile_pkg::OP_INSERT :
               (pick < 72) ? ile_pkg::OP_DELETE : ile_pkg::OP_READ;
        if ($urandom_range(99) < 15)
          pos = 7'($urandom_range(127));
        else if (op == ile_pkg::OP_APPEND || op == ile_pkg::OP_INSERT)
          pos = 7'($urandom_range(len));
        else
          pos = (len == 0) ? 7'd0 : 7'($urandom_range(len - 1));
        send_request(op, pos, $urandom(), 1'b0, ile_pkg::ST_OK, '0);
      end
    end
    req_ch.valid <= 1'b0;

    // Drain: wait for every owed result, then give stray results time to show.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
